FILE: rtl/core/ssa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum slot allocator package
// Shared sizes, request kinds, sequencer states and bit search functions.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int PodCount  = 8;
  localparam int PortCount = 16;
  localparam int SlotCount = 64;
  localparam int PodW      = 3;
  localparam int PortW     = 4;
  localparam int SlotW     = 6;
  localparam int CountW    = 7;
  localparam int AddrW     = PodW + PortW;
  localparam int RowTotal  = PodCount * PortCount;
  localparam int FitSteps  = CountW;

  typedef logic [SlotCount-1:0] row_t;

  typedef enum logic [1:0] {
    KIND_FIND_PAIR = 2'd0,
    KIND_FIND_ONE  = 2'd1,
    KIND_OCCUPY    = 2'd2,
    KIND_RELEASE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_GET_A,
    ST_GET_B,
    ST_FIT,
    ST_EVAL,
    ST_FIN
  } state_t;

  function automatic logic [SlotW-1:0] hi_index(input row_t v);
    logic [SlotW-1:0] r;
    r = '0;
    for (int i = 0; i < SlotCount; i++) begin
      if (v[i]) r = SlotW'(i);
    end
    return r;
  endfunction

  function automatic logic [SlotW-1:0] lo_index(input row_t v);
    logic [SlotW-1:0] r;
    r = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (v[i]) r = SlotW'(i);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/spectrum_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum slot allocator
// A two-pod find reads both pods at each of the 16 ports in turn, fits and
// evaluates each, then registers the answer; a single-port find does one port.
// An occupy or release rewrites one row, or one per pod when both are marked.
// The answer waits for a free output, then the block goes idle for the next
// request. Reset clears the row valid bits at once; every slot then reads free.
// ----------------------------------------------------------------------------
module spectrum_slot_allocator
  import ssa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [PodW-1:0]   pod_a,
  input  logic [PodW-1:0]   pod_b,
  input  logic              both_pods,
  input  logic [PortW-1:0]  port_sel,
  input  logic [SlotW-1:0]  first_slot,
  input  logic [CountW-1:0] slot_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [PortW-1:0]  port_out,
  output logic [SlotW-1:0]  start_out
);

  row_t mem [RowTotal];
  logic [RowTotal-1:0] row_vld;
  row_t rdata;
  logic rdata_vld;

  state_t state, state_next;

  kind_t            req_kind;
  logic [PodW-1:0]  req_pa, req_pb;
  logic             req_both;
  logic [PortW-1:0] req_port;
  logic [SlotW-1:0] req_first;
  logic [CountW-1:0] req_cnt;

  logic [PortW-1:0] port_idx;
  logic             second;
  row_t             row_a, acc, pw;
  logic [CountW-1:0] shift_m;
  logic [2:0]       step;
  logic [SlotW-1:0] score;

  logic             have;
  logic [SlotW-1:0] best_score, best_start;
  logic [PortW-1:0] best_port;

  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr;
  row_t             rd_row, new_row, mask;
  logic [7:0]       end_pos;
  logic             fit, take;
  logic             out_free;

  assign rd_row   = rdata_vld ? rdata : '1;
  assign end_pos  = {2'b00, req_first} + {1'b0, req_cnt};
  assign mask     = ('1 << req_first) & ~('1 << end_pos);
  assign new_row  = (req_kind == KIND_RELEASE) ? (rd_row | mask) : (rd_row & ~mask);
  assign fit      = (acc != '0) && (req_cnt != '0);
  assign take     = fit && (score != SlotW'(SlotCount - 1)) && (!have || score < best_score);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = {second ? req_pb : req_pa, port_idx};
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_ISSUE: rd_en = 1'b1;
      ST_GET_A: begin
        if (req_kind == KIND_FIND_PAIR) begin
          rd_en   = 1'b1;
          rd_addr = {req_pb, port_idx};
        end
        wr_en = (req_kind == KIND_OCCUPY) || (req_kind == KIND_RELEASE);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_GET_A;
      ST_GET_A: begin
        unique case (req_kind)
          KIND_FIND_PAIR: state_next = ST_GET_B;
          KIND_FIND_ONE:  state_next = ST_FIT;
          default:        state_next = (req_both && !second) ? ST_ISSUE : ST_FIN;
        endcase
      end
      ST_GET_B: state_next = ST_FIT;
      ST_FIT:   if (step == 3'(FitSteps - 1)) state_next = ST_EVAL;
      ST_EVAL: begin
        if (req_kind == KIND_FIND_ONE || port_idx == PortW'(PortCount - 1)) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[rd_addr] <= new_row;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld   <= '0;
      rdata_vld <= 1'b0;
    end else begin
      if (wr_en) row_vld[rd_addr] <= 1'b1;
      if (rd_en) rdata_vld <= row_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_kind  <= kind_t'(kind);
          req_pa    <= pod_a;
          req_pb    <= pod_b;
          req_both  <= both_pods;
          req_port  <= port_sel;
          req_first <= first_slot;
          req_cnt   <= slot_count;
          port_idx  <= (kind == KIND_FIND_PAIR) ? '0 : port_sel;
          second    <= 1'b0;
          have      <= 1'b0;
          best_score <= '0;
          best_start <= '0;
          best_port  <= '0;
        end
      end
      ST_GET_A: begin
        row_a   <= rd_row;
        acc     <= '1;
        pw      <= rd_row;
        shift_m <= '0;
        step    <= '0;
        score   <= hi_index(~rd_row);
        second  <= 1'b1;
      end
      ST_GET_B: begin
        pw    <= row_a & rd_row;
        score <= hi_index(~(row_a & rd_row));
      end
      ST_FIT: begin
        if (req_cnt[step]) begin
          acc     <= acc & (pw >> shift_m);
          shift_m <= shift_m + (CountW'(1) << step);
        end
        pw   <= pw & (pw >> (CountW'(1) << step));
        step <= step + 3'd1;
      end
      ST_EVAL: begin
        second <= 1'b0;
        if (req_kind == KIND_FIND_ONE) begin
          have       <= fit;
          best_port  <= fit ? req_port : '0;
          best_start <= fit ? lo_index(acc) : '0;
        end else begin
          if (take) begin
            have       <= 1'b1;
            best_score <= score;
            best_port  <= port_idx;
            best_start <= lo_index(acc);
          end
          port_idx <= port_idx + PortW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      if (req_kind == KIND_OCCUPY || req_kind == KIND_RELEASE) begin
        found     <= 1'b1;
        port_out  <= req_port;
        start_out <= req_first;
      end else begin
        found     <= have;
        port_out  <= best_port;
        start_out <= best_start;
      end
    end
  end

endmodule
